### hw/rtl/pcvw_pkg.sv
// Shared types and constants for the per-channel variance weight unit.
`timescale 1ns / 1ps
`default_nettype none

package pcvw_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REPORT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] REG_TINY_FLOOR   = 2'd0;
   localparam logic [1:0] REG_SMALL_FLOOR  = 2'd1;
   localparam logic [1:0] REG_FEW_LIMIT    = 2'd2;
   localparam logic [1:0] REG_SINGLE_FLOOR = 2'd3;

   localparam logic [31:0] WEIGHT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0]        count;
      logic signed [47:0] sum;
      logic [63:0]        sqsum;
   } entry_type;

   typedef struct packed {
      logic [31:0] tiny_floor;
      logic [31:0] small_floor;
      logic [15:0] few_limit;
      logic [31:0] single_floor;
   } cfg_type;

   typedef struct packed {
      logic        done;
      logic [31:0] weight;
   } rpt_result_type;

endpackage

`default_nettype wire

### hw/rtl/pcvw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module pcvw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/pcvw_report.sv
// Weight engine: multiplies, shared shift-subtract divider and bit-serial square root.
`timescale 1ns / 1ps
`default_nettype none

module pcvw_report
   import pcvw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  entry_type      entry,
   input  cfg_type        cfg,
   output rpt_result_type result
);

   typedef enum logic [3:0] {
      R_IDLE, R_MUL1, R_MUL2, R_MUL3, R_CMP, R_DIV, R_FLOOR, R_SQRT, R_DONE
   } state_type;

   typedef enum logic [1:0] {K_SINGLE, K_VAR, K_RECIP} kind_type;

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] n_ff, n_in;
   logic [47:0] mag_ff, mag_in;
   logic [63:0] sq_ff, sq_in;
   logic [79:0] a_ff, a_in;
   logic [95:0] b_ff, b_in;
   logic [31:0] dsq_ff, dsq_in;
   logic [79:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [31:0] weight_ff, weight_in;

   logic [47:0] start_mag, sd;
   logic [47:0] p_mid;
   logic [31:0] p_hi;
   logic [64:0] t;
   logic        ge;
   logic [79:0] q;
   logic [63:0] vf, rb;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      n_in      = n_ff;
      mag_in    = mag_ff;
      sq_in     = sq_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      dsq_in    = dsq_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      v_in      = v_ff;
      x_in      = x_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      weight_in = weight_ff;

      start_mag = entry.sum[47] ? 48'(-entry.sum) : 48'(entry.sum);
      sd = (start_mag < {16'd0, cfg.single_floor}) ? {16'd0, cfg.single_floor} : start_mag;
      p_mid = 48'(mag_ff[31:0]) * 48'(mag_ff[47:32]);
      p_hi  = 32'(mag_ff[47:32]) * 32'(mag_ff[47:32]);
      t  = {rem_ff[63:0], num_ff[79]};
      ge = t >= {1'b0, den_ff};
      q  = {num_ff[78:0], ge};
      vf = ((v_ff < {32'd0, cfg.tiny_floor}) ||
            ((v_ff < {32'd0, cfg.small_floor}) && (n_ff < cfg.few_limit)))
           ? 64'h1_0000_0000 : v_ff;
      rb = res_ff + bit_ff;

      case (state_ff)
         R_IDLE: begin
            if (start) begin
               n_in   = entry.count;
               mag_in = start_mag;
               sq_in  = entry.sqsum;
               if (entry.count == 16'd1) begin
                  if (sd == 48'd0) begin
                     weight_in = WEIGHT_MAX;
                     state_in  = R_DONE;
                  end else begin
                     num_in   = 80'h1_0000_0000;
                     den_in   = {16'd0, sd};
                     rem_in   = '0;
                     cnt_in   = 7'd79;
                     kind_in  = K_SINGLE;
                     state_in = R_DIV;
                  end
               end else begin
                  state_in = R_MUL1;
               end
            end
         end
         R_MUL1: begin
            a_in     = 80'(sq_ff) * 80'(n_ff);
            b_in     = 96'(64'(mag_ff[31:0]) * 64'(mag_ff[31:0]));
            dsq_in   = 32'(n_ff) * 32'(n_ff);
            state_in = R_MUL2;
         end
         R_MUL2: begin
            b_in     = b_ff + (96'(p_mid) << 33);
            state_in = R_MUL3;
         end
         R_MUL3: begin
            b_in     = b_ff + {p_hi, 64'd0};
            state_in = R_CMP;
         end
         R_CMP: begin
            if ({16'd0, a_ff} < b_ff) begin
               v_in     = 64'h1_0000_0000;
               state_in = R_FLOOR;
            end else begin
               num_in   = 80'({16'd0, a_ff} - b_ff);
               den_in   = {32'd0, dsq_ff};
               rem_in   = '0;
               cnt_in   = 7'd79;
               kind_in  = K_VAR;
               state_in = R_DIV;
            end
         end
         R_DIV: begin
            rem_in = ge ? (t - {1'b0, den_ff}) : t;
            num_in = q;
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               case (kind_ff)
                  K_SINGLE: begin
                     weight_in = (|q[79:32]) ? WEIGHT_MAX : q[31:0];
                     state_in  = R_DONE;
                  end
                  K_VAR: begin
                     v_in     = (|q[79:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
                     state_in = R_FLOOR;
                  end
                  K_RECIP: begin
                     x_in     = q[63:0];
                     res_in   = '0;
                     bit_in   = 64'h4000_0000_0000_0000;
                     cnt_in   = 7'd31;
                     state_in = R_SQRT;
                  end
                  default: state_in = R_IDLE;
               endcase
            end
         end
         R_FLOOR: begin
            if (vf <= 64'd1) begin
               weight_in = WEIGHT_MAX;
               state_in  = R_DONE;
            end else begin
               num_in   = 80'h1_0000_0000_0000_0000;
               den_in   = vf;
               rem_in   = '0;
               cnt_in   = 7'd79;
               kind_in  = K_RECIP;
               state_in = R_DIV;
            end
         end
         R_SQRT: begin
            if (x_ff >= rb) begin
               x_in   = x_ff - rb;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               weight_in = res_in[31:0];
               state_in  = R_DONE;
            end
         end
         R_DONE:  state_in = R_IDLE;
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         kind_ff  <= K_SINGLE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
      n_ff      <= n_in;
      mag_ff    <= mag_in;
      sq_ff     <= sq_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      dsq_ff    <= dsq_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      v_ff      <= v_in;
      x_ff      <= x_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      weight_ff <= weight_in;
   end

   assign result.done   = (state_ff == R_DONE);
   assign result.weight = weight_ff;

endmodule

`default_nettype wire

### hw/rtl/per_channel_variance_weight_unit.sv
// Top level: per-channel sum / sum-of-squares store and inverse stddev reporting.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a count, running sum and sum of squares per channel in one RAM with
// registered read. After reset the block sweeps the RAM to zero, one entry
// per cycle, while req_stall is high (CSR writes are still taken). One
// transaction at a time: an add reads, then writes back, a clear or an
// ignored op needs no further state, and a report for a multi-sample channel
// runs 3 partial-product multiplies, then up to two 80-step divides and a
// 32-step square root on the bit-serial divider and square-root unit, while
// a single-sample channel needs at most one divide. A finished report waits
// in the output register while new transactions are accepted.

module per_channel_variance_weight_unit
   import pcvw_pkg::*;
#(
   parameter int CHANNELS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_channel,
   input  logic [31:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_channel_out,
   output logic [31:0] rsp_weight,
   output logic        rsp_has_samples,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(CHANNELS);

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_ADD, S_RPT_RD, S_RPT_RUN, S_OUT
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [9:0]     chan_ff, chan_in;
   logic [31:0]    smp_ff, smp_in;
   logic [63:0]    sqr_ff, sqr_in;
   logic [31:0]    res_weight_ff, res_weight_in;
   logic           res_has_ff, res_has_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [9:0]     rsp_chan_ff, rsp_chan_in;
   logic [31:0]    rsp_weight_ff, rsp_weight_in;
   logic           rsp_has_ff, rsp_has_in;
   logic [31:0]    tiny_ff, small_ff, single_ff;
   logic [15:0]    few_ff;

   logic           accept, ch_ok, csr_write;
   logic [AW-1:0]  req_addr;
   logic [31:0]    mag32;
   entry_type      rd_entry, wr_entry, upd;
   logic [127:0]   rd_raw;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [48:0]    sum_wide;
   logic [64:0]    sq_wide;
   logic           rpt_start;
   cfg_type        cfg;
   rpt_result_type rpt;

   assign accept    = req_valid && !req_stall;
   assign ch_ok     = 32'(req_channel) < 32'(CHANNELS);
   assign req_addr  = AW'(req_channel);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rd_entry  = entry_type'(rd_raw);
   assign rpt_start = (state_ff == S_RPT_RD) && (rd_entry.count != 16'd0);

   assign cfg.tiny_floor   = tiny_ff;
   assign cfg.small_floor  = small_ff;
   assign cfg.few_limit    = few_ff;
   assign cfg.single_floor = single_ff;

   pcvw_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (req_addr),
      .rd_data (rd_raw)
   );

   pcvw_report u_report (
      .clock  (clock),
      .reset  (reset),
      .start  (rpt_start),
      .entry  (rd_entry),
      .cfg    (cfg),
      .result (rpt)
   );

   always_comb begin
      mag32    = req_sample[31] ? 32'(-req_sample) : req_sample;
      sum_wide = {rd_entry.sum[47], rd_entry.sum} + {{17{smp_ff[31]}}, smp_ff};
      sq_wide  = {1'b0, rd_entry.sqsum} + {1'b0, sqr_ff};
      upd.count = (rd_entry.count == 16'hFFFF) ? rd_entry.count : rd_entry.count + 16'd1;
      if (sum_wide[48] != sum_wide[47]) begin
         upd.sum = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         upd.sum = sum_wide[47:0];
      end
      upd.sqsum = sq_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_wide[63:0];

      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      addr_in       = addr_ff;
      chan_in       = chan_ff;
      smp_in        = smp_ff;
      sqr_in        = sqr_ff;
      res_weight_in = res_weight_ff;
      res_has_in    = res_has_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_chan_in   = rsp_chan_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_has_in    = rsp_has_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_entry      = '0;

      case (state_ff)
         S_CLR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(CHANNELS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               addr_in = req_addr;
               chan_in = req_channel;
               smp_in  = req_sample;
               sqr_in  = 64'(mag32) * 64'(mag32);
               case (req_op)
                  OP_ADD: begin
                     if (ch_ok) begin
                        state_in = S_ADD;
                     end
                  end
                  OP_REPORT: begin
                     if (ch_ok) begin
                        state_in = S_RPT_RD;
                     end else begin
                        res_weight_in = '0;
                        res_has_in    = 1'b0;
                        state_in      = S_OUT;
                     end
                  end
                  OP_CLEAR: begin
                     if (ch_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = req_addr;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ADD: begin
            wr_en    = 1'b1;
            wr_entry = upd;
            state_in = S_IDLE;
         end
         S_RPT_RD: begin
            if (rd_entry.count == 16'd0) begin
               res_weight_in = '0;
               res_has_in    = 1'b0;
               state_in      = S_OUT;
            end else begin
               state_in = S_RPT_RUN;
            end
         end
         S_RPT_RUN: begin
            if (rpt.done) begin
               res_weight_in = rpt.weight;
               res_has_in    = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_chan_in   = chan_ff;
               rsp_weight_in = res_weight_ff;
               rsp_has_in    = res_has_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         tiny_ff      <= 32'd1;
         small_ff     <= 32'd4295;
         few_ff       <= 16'd4;
         single_ff    <= 32'd6554;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_paddr[3:2])
               REG_TINY_FLOOR:   tiny_ff   <= csr_pwdata;
               REG_SMALL_FLOOR:  small_ff  <= csr_pwdata;
               REG_FEW_LIMIT:    few_ff    <= csr_pwdata[15:0];
               REG_SINGLE_FLOOR: single_ff <= csr_pwdata;
               default: ;
            endcase
         end
      end
      addr_ff       <= addr_in;
      chan_ff       <= chan_in;
      smp_ff        <= smp_in;
      sqr_ff        <= sqr_in;
      res_weight_ff <= res_weight_in;
      res_has_ff    <= res_has_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_has_ff    <= rsp_has_in;
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TINY_FLOOR:   csr_prdata = tiny_ff;
         REG_SMALL_FLOOR:  csr_prdata = small_ff;
         REG_FEW_LIMIT:    csr_prdata = {16'd0, few_ff};
         REG_SINGLE_FLOOR: csr_prdata = single_ff;
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready      = 1'b1;
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_chan_ff;
   assign rsp_weight      = rsp_weight_ff;
   assign rsp_has_samples = rsp_has_ff;

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      rpt.done |-> state_ff == S_RPT_RUN)
      else $error("report engine finished outside a report");

   a_no_write_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RPT_RUN |-> !wr_en)
      else $error("RAM written while a report is running");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == S_OUT)
      else $error("pending result dropped while output stalled");

endmodule

`default_nettype wire
